// ===== rtl/core/url_percent_decoder_core_macros.svh =====
// Assertion macros shared by the checker of the URL percent decoder.
`ifndef URL_PERCENT_DECODER_CORE_MACROS_SVH
`define URL_PERCENT_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UPD_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define UPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define UPD_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/upd_pkg.sv =====
// Types, constants and helper functions of the URL percent decoder.
package upd_pkg;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    PH_NONE,
    PH_PCT,
    PH_DIGIT
  } phase_t;

  // One decoded item group: up to three bytes, in order from data[0].
  typedef struct packed {
    logic [1:0]      cnt;
    logic            last;
    logic [2:0][7:0] data;
  } cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (c >= 8'h61) begin
      t = c - 8'h57;
    end else if (c >= 8'h41) begin
      t = c - 8'h37;
    end else begin
      t = c - 8'h30;
    end
    return t[3:0];
  endfunction

endpackage

// ===== rtl/core/url_percent_decoder_core.sv =====
// Top level of the streaming URL form decoder.
// Each input item is one raw character with a last-of-string flag; it yields zero to three
// decoded bytes ('%' with two hex digits becomes one byte, '+' becomes a space, broken
// escapes and anything held at end of string come out literally). The input takes one item
// per cycle while the four-entry group queue has room; the output sends one byte per cycle
// while out_ready is high, so the bytes of one item leave one after another. A byte is
// written into the group queue and then into the output register before it appears.
module url_percent_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_char
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast    // out_last
);
  import upd_pkg::*;

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic empty;
  logic full;

  upd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_char    (s_tdata),
    .in_last    (s_tlast),
    .queue_full (full),
    .in_ready   (s_tready),
    .push       (push),
    .cmd        (push_cmd)
  );

  upd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  upd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .out_ready (m_tready),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_char  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// ===== rtl/core/upd_front.sv =====
// Front part: takes characters, tracks escapes and builds byte groups.
module upd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    in_char,
  input  logic          in_last,
  input  logic          queue_full,
  output logic          in_ready,
  output logic          push,
  output upd_pkg::cmd_t cmd
);
  import upd_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held;
  logic [7:0] held_next;
  logic [1:0] n;
  logic       do_plain;
  logic       accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (n != 2'd0);

  always_comb begin
    cmd.data   = '0;
    n          = 2'd0;
    phase_next = phase;
    held_next  = held;
    do_plain   = 1'b0;
    case (phase)
      PH_PCT: begin
        if (is_hex(in_char)) begin
          if (in_last) begin
            cmd.data[0] = CHAR_PCT;
            cmd.data[1] = in_char;
            n           = 2'd2;
            phase_next  = PH_NONE;
          end else begin
            held_next  = in_char;
            phase_next = PH_DIGIT;
          end
        end else begin
          cmd.data[0] = CHAR_PCT;
          n           = 2'd1;
          do_plain    = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (is_hex(in_char)) begin
          cmd.data[0] = {hex_val(held), hex_val(in_char)};
          n           = 2'd1;
          phase_next  = PH_NONE;
        end else begin
          cmd.data[0] = CHAR_PCT;
          cmd.data[1] = held;
          n           = 2'd2;
          do_plain    = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase
    if (do_plain) begin
      phase_next = PH_NONE;
      if (in_char == CHAR_PCT) begin
        if (in_last) begin
          cmd.data[n] = CHAR_PCT;
          n           = n + 2'd1;
        end else begin
          phase_next = PH_PCT;
        end
      end else if (in_char == CHAR_PLUS) begin
        cmd.data[n] = CHAR_SPACE;
        n           = n + 2'd1;
      end else begin
        cmd.data[n] = in_char;
        n           = n + 2'd1;
      end
    end
    if (in_last) begin
      phase_next = PH_NONE;
      held_next  = '0;
    end
    cmd.cnt  = n;
    cmd.last = in_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NONE;
      held  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

endmodule

// ===== rtl/core/upd_queue.sv =====
// Short queue of byte groups between the front and back parts.
module upd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  upd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output upd_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  import upd_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/upd_back.sv =====
// Back part: sends the bytes of each queued group one per cycle while out_ready is high.
module upd_back (
  input  logic          clk,
  input  logic          rst,
  input  upd_pkg::cmd_t head,
  input  logic          empty,
  input  logic          out_ready,
  output logic          pop,
  output logic          out_valid,
  output logic [7:0]    out_char,
  output logic          out_last
);
  import upd_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       final_byte;

  assign load       = !empty && (!out_valid || out_ready);
  assign final_byte = (idx == (head.cnt - 2'd1));
  assign pop        = load && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_byte ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= head.data[idx];
      out_last <= head.last && final_byte;
    end
  end

endmodule

// ===== rtl/core/upd_checker.sv =====
// Port-level checker of the URL percent decoder and its bind.
`include "url_percent_decoder_core_macros.svh"

module upd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  logic [3:0] lasts_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      lasts_open <= '0;
    end else begin
      lasts_open <= lasts_open + 4'(s_tvalid && s_tready && s_tlast)
                              - 4'(m_tvalid && m_tready && m_tlast);
    end
  end

  `UPD_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
  `UPD_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
  `UPD_ASSERT_NEXT_ALWAYS(a_reset_idle, rst, !m_tvalid)
  `UPD_ASSERT_IMPLY(a_last_matched, m_tvalid && m_tready && m_tlast, lasts_open != 4'd0)

endmodule

bind url_percent_decoder_core upd_checker u_upd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
